// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allpass lattice RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define TVAL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define TVAL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/tval_pkg.sv =====
// Types, constants and the quarter-wave sine table of the allpass lattice.
// Depends on nothing; the design files and the bench use it by scoped names.
package tval_pkg;

   localparam int COEF_W     = 18;
   localparam int FRAC       = COEF_W - 2;
   localparam int SINE_W     = COEF_W - 1;
   localparam int SINE_DEPTH = 1024;
   localparam int DATA_W     = 32;
   localparam int ACC_W      = COEF_W + DATA_W + 1;
   localparam int RES_W      = ACC_W - FRAC;
   localparam int RATE_W     = 18;
   localparam int FREQ_W     = 17;
   localparam int ROM_AW     = $clog2(SINE_DEPTH + 1);
   localparam int POS_W      = $clog2(2 * SINE_DEPTH + 1);
   localparam int POS_MUL    = 8 * SINE_DEPTH;
   localparam int DIV_NW     = 33;
   localparam int DIV_DW     = 19;
   localparam int SQ_RW      = 17;
   localparam int SQ_VW      = 2 * SQ_RW;
   localparam int COEF_ONE   = 1 << FRAC;
   localparam longint ONE_SQ = 64'sd1 << (2 * FRAC);
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam int RATE_RESET = 44100;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [RES_W-1:0]  res_type;
   typedef logic [SINE_W-1:0]        sine_type;
   typedef sine_type                 sine_rom_type [SINE_DEPTH+1];

   // Long division by shift and subtract, used while building the table.
   function automatic longint unsigned div_u64(longint unsigned num,
                                               longint unsigned dvs);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         quo = quo << 1;
         if (rem >= dvs) begin
            rem = rem - dvs;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // Build the table with an eleven-term Taylor series in Q30.
   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint e;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         x    = (PI_Q30 * longint'(k)) / (2 * SINE_DEPTH);
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 10; n++) begin
            term = div_u64((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         e = (sum + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
         if (e > COEF_ONE) begin
            e = COEF_ONE;
         end
         rom[k] = SINE_W'(e);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

endpackage

// ===== rtl/time_varying_allpass_lattice_unit.sv =====
// Second-order time-varying allpass lattice. One request carries a sample,
// a pi-phase frequency and a bandwidth; one response sample follows. A new
// request is accepted only in the idle state, and each one runs in sequence
// through the accepting cycle, two table-position divisions, four sine
// table reads, a division for cos1, a square root for sin1, four bit-serial
// multiply-accumulate passes and the load of the output register, all
// through the shared divider, root unit and MAC. The finished sample waits
// in an output register, so the next request can start while it is unread;
// a response still unread when the next one finishes stalls the unit.
// Write sample_rate on the csr port only while no request is in flight.
// Depends on tval_pkg, tval_div, tval_sqrt, tval_mac and assert_macros.svh.
`include "assert_macros.svh"

module time_varying_allpass_lattice_unit #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample_in,
   input  logic [tval_pkg::FREQ_W-1:0]     req_pi_freq_hz,
   input  logic [tval_pkg::FREQ_W-1:0]     req_bandwidth_hz,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_sample_out,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tval_pkg::RATE_W-1:0]     csr_data
);
   localparam int SD   = tval_pkg::SINE_DEPTH;
   localparam int PW   = tval_pkg::POS_W;
   localparam int NW   = tval_pkg::DIV_NW;
   localparam int DW   = tval_pkg::DIV_DW;
   localparam int RW   = tval_pkg::RES_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIVPI = 4'd1;
   localparam logic [3:0] ST_DIVB  = 4'd2;
   localparam logic [3:0] ST_RD0   = 4'd3;
   localparam logic [3:0] ST_RD1   = 4'd4;
   localparam logic [3:0] ST_RD2   = 4'd5;
   localparam logic [3:0] ST_RD3   = 4'd6;
   localparam logic [3:0] ST_RD4   = 4'd7;
   localparam logic [3:0] ST_DIVC1 = 4'd8;
   localparam logic [3:0] ST_SQRT  = 4'd9;
   localparam logic [3:0] ST_MACA  = 4'd10;
   localparam logic [3:0] ST_MACY  = 4'd11;
   localparam logic [3:0] ST_MACH1 = 4'd12;
   localparam logic [3:0] ST_MACH2 = 4'd13;
   localparam logic [3:0] ST_DONE  = 4'd14;

   localparam logic [PW-1:0] POS_HALF = PW'(2 * SD);
   localparam logic [PW-1:0] POS_BMAX = PW'(2 * SD - 1);
   localparam logic [PW-1:0] POS_QTR  = PW'(SD);
   localparam tval_pkg::res_type ST_MAX = RW'(64'sh7FFFFFFF);
   localparam tval_pkg::res_type ST_MIN = -RW'(64'sh80000000);
   localparam tval_pkg::res_type SMP_MAX = RW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam tval_pkg::res_type SMP_MIN = -RW'(64'sd1 <<< (SAMPLE_WIDTH - 1));

   logic [3:0]                      state_ff, state_in;
   logic                            launch_ff, launch_in;
   tval_pkg::data_type              x_ff, x_in;
   logic [tval_pkg::FREQ_W-1:0]     fpi_ff, fpi_in, fb_ff, fb_in;
   logic [tval_pkg::RATE_W-1:0]     fs_ff, fs_in, rate_ff;
   logic [PW-1:0]                   pos_pi_ff, pos_pi_in, pos_b_ff, pos_b_in;
   tval_pkg::coef_type              cos2_ff, cos2_in, sin2_ff, sin2_in;
   tval_pkg::coef_type              cos1_ff, cos1_in, sin1_ff, sin1_in;
   tval_pkg::sine_type              cbmag_ff, cbmag_in, sb_ff, sb_in;
   tval_pkg::sine_type              c1mag_ff, c1mag_in;
   logic                            cbneg_ff, cbneg_in;
   tval_pkg::data_type              a_ff, a_in, h1n_ff, h1n_in;
   tval_pkg::data_type              hist1_ff, hist1_in, hist2_ff, hist2_in;
   logic signed [SAMPLE_WIDTH-1:0]  y_ff, y_in, rsp_data_ff, rsp_data_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [tval_pkg::ROM_AW-1:0]     rom_addr;
   tval_pkg::sine_type              rom_ff;
   tval_pkg::coef_type              rom_coef;

   logic [NW-1:0]                   div_num, div_quo;
   logic [DW-1:0]                   div_den;
   logic                            div_start, div_done;
   logic [tval_pkg::SQ_VW-1:0]      sq_rad;
   logic [tval_pkg::SQ_RW-1:0]      sq_root;
   logic                            sq_start, sq_done;
   tval_pkg::coef_type              mac_ca, mac_cb;
   tval_pkg::data_type              mac_p, mac_q;
   tval_pkg::res_type               mac_res;
   logic                            mac_start, mac_done;
   logic [PW-1:0]                   quo_pos;
   logic                            out_load;

   // Table address of the cosine or sine at a half-circle position.
   function automatic logic [tval_pkg::ROM_AW-1:0] table_addr(logic [PW-1:0] pos,
                                                              logic want_cos);
      logic [PW-1:0] a;
      if (pos <= POS_QTR) begin
         a = want_cos ? POS_QTR - pos : pos;
      end else begin
         a = want_cos ? pos - POS_QTR : POS_HALF - pos;
      end
      return tval_pkg::ROM_AW'(a);
   endfunction

   // Saturate a rounded sum to the state width.
   function automatic tval_pkg::data_type sat_state(tval_pkg::res_type v);
      tval_pkg::res_type c;
      c = v > ST_MAX ? ST_MAX : (v < ST_MIN ? ST_MIN : v);
      return tval_pkg::DATA_W'(c);
   endfunction

   // Pick the table address for the read in flight.
   always_comb begin
      case (state_ff)
         ST_RD0:  rom_addr = table_addr(pos_pi_ff, 1'b1);
         ST_RD1:  rom_addr = table_addr(pos_pi_ff, 1'b0);
         ST_RD2:  rom_addr = table_addr(pos_b_ff, 1'b1);
         default: rom_addr = table_addr(pos_b_ff, 1'b0);
      endcase
   end

   // Read the quarter-wave table with a registered output.
   always_ff @(posedge clock) begin
      rom_ff <= tval_pkg::SINE_ROM[rom_addr];
   end
   assign rom_coef = {1'b0, rom_ff};

   // Feed the shared divider.
   always_comb begin
      if (state_ff == ST_DIVC1) begin
         div_den = DW'(tval_pkg::COEF_ONE) + DW'(sb_ff);
         div_num = (NW'(cbmag_ff) << tval_pkg::FRAC) + NW'(div_den >> 1);
      end else begin
         div_den = DW'(fs_ff) << 1;
         if (state_ff == ST_DIVPI) begin
            div_num = NW'(fpi_ff) * NW'(tval_pkg::POS_MUL) + NW'(fs_ff);
         end else begin
            div_num = NW'(fb_ff) * NW'(tval_pkg::POS_MUL) + NW'(fs_ff);
         end
      end
   end
   assign div_start = launch_ff && (state_ff == ST_DIVPI || state_ff == ST_DIVB ||
                                    state_ff == ST_DIVC1);
   assign quo_pos   = (div_quo > NW'(POS_HALF)) ? POS_HALF : PW'(div_quo);

   assign sq_rad   = tval_pkg::SQ_VW'(tval_pkg::ONE_SQ) -
                     tval_pkg::SQ_VW'(c1mag_ff) * tval_pkg::SQ_VW'(c1mag_ff);
   assign sq_start = launch_ff && state_ff == ST_SQRT;

   // Route coefficients and operands to the MAC for each lattice product.
   always_comb begin
      case (state_ff)
         ST_MACA: begin
            mac_ca = cos2_ff;  mac_cb = -sin2_ff;  mac_p = hist1_ff;  mac_q = hist2_ff;
         end
         ST_MACY: begin
            mac_ca = cos1_ff;  mac_cb = -sin1_ff;  mac_p = x_ff;      mac_q = a_ff;
         end
         ST_MACH1: begin
            mac_ca = sin1_ff;  mac_cb = cos1_ff;   mac_p = x_ff;      mac_q = a_ff;
         end
         default: begin
            mac_ca = sin2_ff;  mac_cb = cos2_ff;   mac_p = hist1_ff;  mac_q = hist2_ff;
         end
      endcase
   end
   assign mac_start = launch_ff && (state_ff == ST_MACA || state_ff == ST_MACY ||
                                    state_ff == ST_MACH1 || state_ff == ST_MACH2);

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequence one request through the shared units.
   always_comb begin
      state_in    = state_ff;
      launch_in   = 1'b0;
      x_in        = x_ff;
      fpi_in      = fpi_ff;
      fb_in       = fb_ff;
      fs_in       = fs_ff;
      pos_pi_in   = pos_pi_ff;
      pos_b_in    = pos_b_ff;
      cos2_in     = cos2_ff;
      sin2_in     = sin2_ff;
      cbmag_in    = cbmag_ff;
      cbneg_in    = cbneg_ff;
      sb_in       = sb_ff;
      c1mag_in    = c1mag_ff;
      cos1_in     = cos1_ff;
      sin1_in     = sin1_ff;
      a_in        = a_ff;
      h1n_in      = h1n_ff;
      hist1_in    = hist1_ff;
      hist2_in    = hist2_ff;
      y_in        = y_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in      = tval_pkg::DATA_W'(req_sample_in);
               fpi_in    = req_pi_freq_hz;
               fb_in     = req_bandwidth_hz;
               fs_in     = (rate_ff == '0) ? tval_pkg::RATE_W'(1) : rate_ff;
               launch_in = 1'b1;
               state_in  = ST_DIVPI;
            end
         end
         ST_DIVPI: begin
            if (div_done) begin
               pos_pi_in = quo_pos;
               launch_in = 1'b1;
               state_in  = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (div_done) begin
               pos_b_in = (quo_pos > POS_BMAX) ? POS_BMAX : quo_pos;
               state_in = ST_RD0;
            end
         end
         ST_RD0: state_in = ST_RD1;
         ST_RD1: begin
            cos2_in  = (pos_pi_ff > POS_QTR) ? -rom_coef : rom_coef;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            sin2_in  = rom_coef;
            state_in = ST_RD3;
         end
         ST_RD3: begin
            cbmag_in = rom_ff;
            cbneg_in = pos_b_ff > POS_QTR;
            state_in = ST_RD4;
         end
         ST_RD4: begin
            sb_in     = rom_ff;
            launch_in = 1'b1;
            state_in  = ST_DIVC1;
         end
         ST_DIVC1: begin
            if (div_done) begin
               c1mag_in  = tval_pkg::SINE_W'(div_quo);
               cos1_in   = cbneg_ff ? -tval_pkg::COEF_W'(div_quo)
                                    : tval_pkg::COEF_W'(div_quo);
               launch_in = 1'b1;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               sin1_in   = tval_pkg::COEF_W'(sq_root);
               launch_in = 1'b1;
               state_in  = ST_MACA;
            end
         end
         ST_MACA: begin
            if (mac_done) begin
               a_in      = sat_state(mac_res);
               launch_in = 1'b1;
               state_in  = ST_MACY;
            end
         end
         ST_MACY: begin
            if (mac_done) begin
               y_in = (mac_res > SMP_MAX) ? SAMPLE_WIDTH'(SMP_MAX) :
                      (mac_res < SMP_MIN) ? SAMPLE_WIDTH'(SMP_MIN) :
                      SAMPLE_WIDTH'(mac_res);
               launch_in = 1'b1;
               state_in  = ST_MACH1;
            end
         end
         ST_MACH1: begin
            if (mac_done) begin
               h1n_in    = sat_state(mac_res);
               launch_in = 1'b1;
               state_in  = ST_MACH2;
            end
         end
         ST_MACH2: begin
            if (mac_done) begin
               hist2_in = sat_state(mac_res);
               hist1_in = h1n_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_data_in  = y_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      fpi_ff      <= fpi_in;
      fb_ff       <= fb_in;
      fs_ff       <= fs_in;
      pos_pi_ff   <= pos_pi_in;
      pos_b_ff    <= pos_b_in;
      cos2_ff     <= cos2_in;
      sin2_ff     <= sin2_in;
      cbmag_ff    <= cbmag_in;
      cbneg_ff    <= cbneg_in;
      sb_ff       <= sb_in;
      c1mag_ff    <= c1mag_in;
      cos1_ff     <= cos1_in;
      sin1_ff     <= sin1_in;
      a_ff        <= a_in;
      h1n_ff      <= h1n_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         hist1_ff     <= '0;
         hist2_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= tval_pkg::RATE_W'(tval_pkg::RATE_RESET);
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         hist1_ff     <= hist1_in;
         hist2_ff     <= hist2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            rate_ff <= csr_data;
         end
      end
   end

   tval_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (div_den), .done (div_done), .quo (div_quo)
   );

   tval_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sq_start),
      .rad (sq_rad), .done (sq_done), .root (sq_root)
   );

   tval_mac u_mac (
      .clock (clock), .reset (reset), .start (mac_start),
      .coef_a (mac_ca), .coef_b (mac_cb), .p (mac_p), .q (mac_q),
      .done (mac_done), .res (mac_res)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign csr_ready      = 1'b1;

   // Checks on sequencing and coefficient ranges.
   `TVAL_ASSERT_NEXT(a_req_takes_busy, clock, reset, req_valid && req_ready, !req_ready)
   `TVAL_ASSERT_NEXT(a_out_load, clock, reset, out_load, rsp_valid)
   `TVAL_ASSERT_NOW(a_pos_range, clock, reset, state_ff == ST_RD0, pos_pi_ff <= POS_HALF && pos_b_ff <= POS_BMAX)
   `TVAL_ASSERT_NOW(a_sin1_range, clock, reset, state_ff == ST_MACA, sin1_ff >= 0 && sin1_ff <= tval_pkg::COEF_W'(tval_pkg::COEF_ONE))
endmodule

// ===== rtl/tval_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// Uses widths from tval_pkg.
module tval_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tval_pkg::DIV_NW-1:0] num,
   input  logic [tval_pkg::DIV_DW-1:0] den,
   output logic                       done,
   output logic [tval_pkg::DIV_NW-1:0] quo
);
   localparam int NW = tval_pkg::DIV_NW;
   localparam int DW = tval_pkg::DIV_DW;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   // Shift one numerator bit into the remainder and try the subtract.
   always_comb begin
      trial   = {rem_ff, num_ff[NW-1]};
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = DW'(trial);
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

// ===== rtl/tval_sqrt.sv =====
// Integer square root, floor, two radicand bits per cycle.
// Uses widths from tval_pkg.
module tval_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tval_pkg::SQ_VW-1:0] rad,
   output logic                       done,
   output logic [tval_pkg::SQ_RW-1:0] root
);
   localparam int RW = tval_pkg::SQ_RW;
   localparam int VW = tval_pkg::SQ_VW;
   localparam int CW = $clog2(RW + 1);

   logic [VW-1:0]   rad_ff, rad_in;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [RW+3:0]   cur;
   logic [RW+3:0]   tri_val;

   // Bring down two bits, compare against 4*root+1.
   always_comb begin
      cur     = {rem_ff, rad_ff[VW-1:VW-2]};
      tri_val = (RW + 4)'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (cur >= tri_val) begin
            rem_in  = (RW + 2)'(cur - tri_val);
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = (RW + 2)'(cur);
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== rtl/tval_mac.sv =====
// Bit-serial dual multiply-accumulate: ca*p + cb*q, rounded by FRAC bits.
// Coefficient bits enter one per cycle; uses types from tval_pkg.
module tval_mac (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  tval_pkg::coef_type  coef_a,
   input  tval_pkg::coef_type  coef_b,
   input  tval_pkg::data_type  p,
   input  tval_pkg::data_type  q,
   output logic                done,
   output tval_pkg::res_type   res
);
   localparam int AW = tval_pkg::ACC_W;
   localparam int CWID = tval_pkg::COEF_W;
   localparam int CW = $clog2(CWID);
   localparam logic signed [AW-1:0] HALF = AW'(1) <<< (tval_pkg::FRAC - 1);

   logic [CWID-1:0]        ca_ff, ca_in, cb_ff, cb_in;
   logic signed [AW-1:0]   pa_ff, pa_in, qb_ff, qb_in, acc_ff, acc_in;
   logic signed [AW-1:0]   ta, tb, rnd;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in, done_ff, done_in, last;

   // Add the shifted operands for the current coefficient bit; sign bit subtracts.
   always_comb begin
      last    = (cnt_ff == CW'(CWID - 1));
      ta      = ca_ff[0] ? (last ? -pa_ff : pa_ff) : '0;
      tb      = cb_ff[0] ? (last ? -qb_ff : qb_ff) : '0;
      ca_in   = ca_ff;
      cb_in   = cb_ff;
      pa_in   = pa_ff;
      qb_in   = qb_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         ca_in   = coef_a;
         cb_in   = coef_b;
         pa_in   = AW'(p);
         qb_in   = AW'(q);
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + ta + tb;
         ca_in  = ca_ff >> 1;
         cb_in  = cb_ff >> 1;
         pa_in  = pa_ff <<< 1;
         qb_in  = qb_ff <<< 1;
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ca_ff  <= ca_in;
      cb_ff  <= cb_in;
      pa_ff  <= pa_in;
      qb_ff  <= qb_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Round half up, then drop the fraction bits.
   assign rnd  = acc_ff + HALF;
   assign res  = tval_pkg::RES_W'(rnd >>> tval_pkg::FRAC);
   assign done = done_ff;
endmodule

// ===== bench/tb_time_varying_allpass_lattice_unit.sv =====
// Self-checking bench for time_varying_allpass_lattice_unit: random bursts of
// requests, a stalling receiver and a built-in lattice predictor per request.
// Depends on tval_pkg and the unit RTL only.
module tb_time_varying_allpass_lattice_unit;

   localparam int SW        = 24;
   localparam int DEPTH     = tval_pkg::SINE_DEPTH;
   localparam int FB        = tval_pkg::FRAC;
   localparam longint ONE   = 64'sd1 << FB;
   localparam longint S_MAX = 64'sd2147483647;
   localparam longint S_MIN = -64'sd2147483648;
   localparam longint O_MAX = (64'sd1 <<< (SW - 1)) - 1;
   localparam longint O_MIN = -(64'sd1 <<< (SW - 1));
   localparam int IDLE_WAIT = 400;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic signed [SW-1:0] sample;
      logic [16:0]          pi_freq;
      logic [16:0]          bw_freq;
   } audio_req_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SW-1:0] req_sample_in = '0;
   logic [16:0] req_pi_freq_hz = '0;
   logic [16:0] req_bandwidth_hz = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_sample_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [17:0] csr_data = '0;

   audio_req_t pending_reqs [$];
   logic signed [SW-1:0] expected_samples [$];
   longint sine_q [DEPTH+1];
   longint hist_one, hist_two;
   int unsigned rate_cfg;
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int idle_cycles = 0;
   bit req_fire = 0;
   bit hold_sender = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int unsigned cyc = 0;

   time_varying_allpass_lattice_unit #(.SAMPLE_WIDTH(SW)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_in(req_sample_in), .req_pi_freq_hz(req_pi_freq_hz),
      .req_bandwidth_hz(req_bandwidth_hz),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Fill the quarter-wave sine table from a Q30 Taylor series.
   function automatic void fill_sine();
      longint unsigned x, x2, term;
      longint sum, e;
      for (int k = 0; k <= DEPTH; k++) begin
         x = (64'd3373259426 * longint'(k)) / (2 * DEPTH);
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            sum = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         e = (sum + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
         sine_q[k] = (e > ONE) ? ONE : e;
      end
   endfunction

   function automatic longint unsigned table_pos(longint unsigned f, longint unsigned fs,
                                                 longint unsigned lim);
      longint unsigned p;
      p = (f * 8 * DEPTH + fs) / (2 * fs);
      return (p > lim) ? lim : p;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint round_q(longint v, longint lo, longint hi);
      longint t;
      t = (v + (64'sd1 <<< (FB - 1))) >>> FB;
      return (t < lo) ? lo : ((t > hi) ? hi : t);
   endfunction

   // Advance the lattice by one sample and return the filtered output.
   function automatic logic signed [SW-1:0] lattice_step(audio_req_t r);
      longint unsigned fs, p_pi, p_bw, mag, den, q;
      longint x, c2, s2, cb, sb, c1, s1, a, y, h1, h2;
      fs = (rate_cfg == 0) ? 1 : rate_cfg;
      x = longint'(r.sample);
      p_pi = table_pos(r.pi_freq, fs, 2 * DEPTH);
      p_bw = table_pos(r.bw_freq, fs, 2 * DEPTH - 1);
      if (p_pi <= DEPTH) begin
         c2 = sine_q[DEPTH - p_pi]; s2 = sine_q[p_pi];
      end else begin
         c2 = -sine_q[p_pi - DEPTH]; s2 = sine_q[2 * DEPTH - p_pi];
      end
      if (p_bw <= DEPTH) begin
         cb = sine_q[DEPTH - p_bw]; sb = sine_q[p_bw];
      end else begin
         cb = -sine_q[p_bw - DEPTH]; sb = sine_q[2 * DEPTH - p_bw];
      end
      mag = longint'(cb < 0 ? -cb : cb) * ONE;
      den = ONE + sb;
      q = (mag + den / 2) / den;
      c1 = (cb < 0) ? -longint'(q) : longint'(q);
      s1 = longint'(int_sqrt(ONE * ONE - c1 * c1));
      a  = round_q(c2 * hist_one - s2 * hist_two, S_MIN, S_MAX);
      y  = round_q(c1 * x - s1 * a, O_MIN, O_MAX);
      h1 = round_q(s1 * x + c1 * a, S_MIN, S_MAX);
      h2 = round_q(s2 * hist_one + c2 * hist_two, S_MIN, S_MAX);
      hist_one = h1;
      hist_two = h2;
      return y[SW-1:0];
   endfunction

   function automatic logic [16:0] rand_freq(int unsigned rate);
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0) return 17'($urandom);
      if (k == 1) return 17'(rate / 2 + $urandom_range(0, 3));
      return 17'($urandom_range(0, rate / 2));
   endfunction

   function automatic logic signed [SW-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return {1'b0, {(SW-1){1'b1}}};
         1: return {1'b1, {(SW-1){1'b0}}};
         2: return SW'($signed($urandom_range(0, 2000)) - 1000);
         default: return SW'($urandom);
      endcase
   endfunction

   task automatic write_rate(input logic [17:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_samples.size() != 0 || req_valid)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic push_req(logic signed [SW-1:0] s, logic [16:0] fp, logic [16:0] fb);
      audio_req_t r;
      r.sample = s;
      r.pi_freq = fp;
      r.bw_freq = fb;
      pending_reqs.push_back(r);
   endtask

   // Hold reset, run the directed corners, then one phase per sample rate setting.
   initial begin
      int unsigned rates [6];
      int unsigned rt;
      rates = '{44100, 8000, 192000, 0, 262143, 48000};
      fill_sine();
      hist_one = 0;
      hist_two = 0;
      rate_cfg = tval_pkg::RATE_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners at the reset rate.
      push_req(0, 0, 0);
      push_req({1'b0, {(SW-1){1'b1}}}, 0, 0);
      push_req({1'b1, {(SW-1){1'b0}}}, 22050, 0);
      push_req({1'b0, {(SW-1){1'b1}}}, 11025, 22049);
      push_req({1'b1, {(SW-1){1'b0}}}, 22050, 22050);
      push_req({1'b0, {(SW-1){1'b1}}}, 17'h1FFFF, 17'h1FFFF);
      push_req({1'b1, {(SW-1){1'b0}}}, 96000, 96000);
      push_req(1, 1, 1);
      push_req(-1, 30000, 10);
      push_req({1'b0, {(SW-1){1'b1}}}, 22000, 22000);
      push_req({1'b0, {(SW-1){1'b1}}}, 5000, 21000);
      push_req({1'b1, {(SW-1){1'b0}}}, 17000, 200);
      push_req(24'sh555555, 17'h0AAAA, 17'h15555);
      push_req(24'shAAAAAA, 17'h15555, 17'h0AAAA);
      wait_drained();

      foreach (rates[i]) begin
         rt = rates[i];
         if (i != 0) write_rate(18'(rt));
         for (int n = 0; n < 100; n++)
            push_req(rand_sample(), rand_freq(rt), rand_freq(rt));
         wait_drained();
      end

      $display("Covered %0d requests, %0d responses checked over six sample rates",
               n_sent, n_checked);
      $display("including zero and full-scale rates, clamped frequencies and saturation");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Drive requests in bursts with random gaps.
   always @(negedge clock) begin
      audio_req_t r;
      logic nv;
      nv = req_valid;
      if (!reset && (!req_valid || req_fire)) begin
         nv = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() != 0 && !hold_sender) begin
            r = pending_reqs.pop_front();
            req_sample_in <= r.sample;
            req_pi_freq_hz <= r.pi_freq;
            req_bandwidth_hz <= r.bw_freq;
            nv = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            end
         end
      end
      req_valid <= nv;
   end

   // Stall the receiver on its own schedule.
   always @(negedge clock) begin
      cyc++;
      if (cyc % 2000 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= (cyc % 512) > 300;
         default: rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // Sample handshakes, predict and check.
   always @(posedge clock) begin
      logic signed [SW-1:0] exp_s;
      audio_req_t r;
      req_fire = req_valid && req_ready && !reset;
      if (!reset) begin
         idle_cycles++;
         if (csr_valid && csr_ready) begin
            rate_cfg = csr_data;
            idle_cycles = 0;
         end
         if (req_fire) begin
            r.sample = req_sample_in;
            r.pi_freq = req_pi_freq_hz;
            r.bw_freq = req_bandwidth_hz;
            expected_samples.push_back(lattice_step(r));
            n_sent++;
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (expected_samples.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response %0d", rsp_sample_out);
            end else begin
               exp_s = expected_samples.pop_front();
               n_checked++;
               if (rsp_sample_out !== exp_s) begin
                  errors++;
                  if (errors <= 10)
                     $display("sample_out mismatch: expected %0d got %0d",
                              exp_s, rsp_sample_out);
               end
            end
         end
         // Give up when nothing moves for too long.
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tval_pkg.sv
rtl/tval_div.sv
rtl/tval_sqrt.sv
rtl/tval_mac.sv
rtl/time_varying_allpass_lattice_unit.sv
bench/tb_time_varying_allpass_lattice_unit.sv
